// ----- rtl/tmfb_pkg.sv -----
// tmfb_pkg: shared types for the timestamp match frame buffer
// payload structs for both channels, entry and cell command types
// no dependencies
package tmfb_pkg;

    localparam int TagW    = 32;
    localparam int StampW  = 63;

    localparam logic       MODE_PUT     = 1'b0;
    localparam logic [1:0] ST_DEFAULT   = 2'd0;
    localparam logic [1:0] ST_GROWN     = 2'd1;
    localparam logic [1:0] ST_MATCHED   = 2'd2;
    localparam logic       CFG_DEF_TAG  = 1'b0;
    localparam logic       CFG_DEF_STMP = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [TagW-1:0]   frame_tag;
        logic [StampW-1:0] stamp;
    } t_in;

    typedef struct packed {
        logic [TagW-1:0]   out_frame_tag;
        logic [StampW-1:0] out_stamp;
        logic [1:0]        out_status;
        logic              out_last;
    } t_out;

    typedef struct packed {
        logic [TagW-1:0]   tag;
        logic [StampW-1:0] stamp;
    } t_entry;

    // broadcast to every cell of the row
    typedef struct packed {
        logic rotate;
        logic compact;
        logic write;
    } t_cmd;

endpackage

// ----- rtl/tmfb_cell.sv -----
// tmfb_cell: one slot of the entry row
// holds an entry and a removal mark, shifts from its upper neighbor
// depends on tmfb_pkg
module tmfb_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tmfb_pkg::t_cmd   i_cmd,
    input  logic            i_wr_sel,
    input  tmfb_pkg::t_entry i_wr_entry,
    input  tmfb_pkg::t_entry i_next,
    input  logic            i_next_dead,
    input  logic            i_hole_in,
    output tmfb_pkg::t_entry o_entry,
    output logic            o_dead,
    output logic            o_hole_out
);

    tmfb_pkg::t_entry r_entry;
    logic             r_dead;
    logic             w_shift;

    // in compaction every cell at or above the lowest marked slot moves down
    assign w_shift    = i_cmd.rotate | (i_cmd.compact & (i_hole_in | r_dead));
    assign o_hole_out = i_hole_in | r_dead;
    assign o_entry    = r_entry;
    assign o_dead     = r_dead;

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_entry <= i_next;
        end else if (i_cmd.write && i_wr_sel) begin
            r_entry <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead <= 1'b0;
        end else if (w_shift) begin
            r_dead <= i_next_dead;
        end
    end

endmodule

// ----- rtl/timestamp_match_frame_buffer.sv -----
// timestamp_match_frame_buffer: top level, row of tmfb_cell slots plus query sequencer
// put: written into the selected slot. query: scan of every slot, decide, emit rotation and
// flush, then compaction per removed entry; output stalls can hold emit and flush
// empty query or growth: result comes from the result register; a waiting result stalls input
// reset (synchronous, active low) empties the store, capacity to START_CAPACITY limited to DEPTH
// depends on tmfb_pkg and tmfb_cell
module timestamp_match_frame_buffer #(
    parameter int DEPTH          = 32,
    parameter int START_CAPACITY = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  tmfb_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output tmfb_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_idx,
    input  logic [tmfb_pkg::StampW-1:0]    i_cfg_data
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IW  = $clog2(DEPTH);
    localparam int CAP0 = (START_CAPACITY > DEPTH) ? DEPTH : START_CAPACITY;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SCAN    = 6'b000010,
        S_DECIDE  = 6'b000100,
        S_EMIT    = 6'b001000,
        S_FLUSH   = 6'b010000,
        S_COMPACT = 6'b100000
    } t_state;

    t_state r_state;

    logic [CW-1:0]               r_count, r_ws, r_cap, r_idx, r_rm, r_below;
    logic [tmfb_pkg::TagW-1:0]   r_def_tag, r_held_tag;
    logic [tmfb_pkg::StampW-1:0] r_def_stamp, r_qstamp, r_best_d, r_best_stamp;
    logic                        r_held_v, r_pend_v, r_res_v;
    tmfb_pkg::t_entry            r_old, r_pend;
    tmfb_pkg::t_out              r_out, r_res;
    logic                        r_out_v;

    tmfb_pkg::t_cmd              w_cmd;
    tmfb_pkg::t_entry            w_ent  [DEPTH];
    logic                        w_dead [DEPTH];
    logic                        w_hole [DEPTH+1];
    logic [DEPTH-1:0]            w_sel;
    logic                        w_tail_dead;
    tmfb_pkg::t_entry            w_wr;
    tmfb_pkg::t_entry            w_head;

    logic                        w_in_xfer, w_out_free, w_out_load;
    tmfb_pkg::t_out              w_out_next;
    logic [CW-1:0]               w_slot, w_ws_inc;
    logic [CW:0]                 w_cap2;
    logic                        w_live, w_rm, w_step, w_last_step;
    logic [tmfb_pkg::StampW-1:0] w_d;

    assign w_head      = w_ent[0];
    // a result still waiting for the output register holds off the next transfer
    assign o_in_stall  = (r_state != S_IDLE) || r_res_v;
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_v || !i_out_stall;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // put slot selection
    always_comb begin
        w_slot = (r_ws >= r_count) ? r_count : r_ws;
        if (w_slot >= CW'(DEPTH)) begin
            w_slot = '0;
        end
        w_ws_inc = r_ws + CW'(1);
        w_cap2   = {r_cap, 1'b0};
        w_wr.tag   = i_in_data.frame_tag;
        w_wr.stamp = i_in_data.stamp;
        w_sel = '0;
        w_sel[w_slot[IW-1:0]] = 1'b1;
    end

    assign w_live      = (r_idx < r_count);
    assign w_d         = (w_head.stamp > r_qstamp) ? (w_head.stamp - r_qstamp)
                                                    : (r_qstamp - w_head.stamp);
    assign w_rm        = w_live && (w_head.stamp <= r_best_stamp);
    assign w_last_step = (r_idx == CW'(DEPTH - 1));
    // a second removal must wait until the previous one can leave
    assign w_step      = !(w_rm && r_pend_v && !w_out_free);

    always_comb begin
        w_cmd.write   = w_in_xfer && (i_in_data.mode == tmfb_pkg::MODE_PUT);
        w_cmd.rotate  = (r_state == S_SCAN) || ((r_state == S_EMIT) && w_step);
        w_cmd.compact = (r_state == S_COMPACT);
        w_tail_dead   = (r_state == S_EMIT) && w_rm;
    end

    assign w_hole[0] = 1'b0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        tmfb_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_wr_sel    (w_sel[k]),
            .i_wr_entry  (w_wr),
            .i_next      ((k == DEPTH - 1) ? w_ent[0] : w_ent[(k + 1) % DEPTH]),
            .i_next_dead ((k == DEPTH - 1) ? w_tail_dead : w_dead[(k + 1) % DEPTH]),
            .i_hole_in   (w_hole[k]),
            .o_entry     (w_ent[k]),
            .o_dead      (w_dead[k]),
            .o_hole_out  (w_hole[k+1])
        );
    end

    // output register source
    always_comb begin
        w_out_load = 1'b0;
        w_out_next = r_res;
        if (r_res_v && w_out_free) begin
            w_out_load = 1'b1;
        end else if (r_state == S_EMIT && w_rm && r_pend_v && w_out_free) begin
            w_out_load = 1'b1;
            w_out_next = '{r_pend.tag, r_pend.stamp, tmfb_pkg::ST_MATCHED, 1'b0};
        end else if (r_state == S_FLUSH && w_out_free) begin
            w_out_load = 1'b1;
            w_out_next = '{r_pend.tag, r_pend.stamp, tmfb_pkg::ST_MATCHED, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_out_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_load) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_tag   <= '0;
            r_def_stamp <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tmfb_pkg::CFG_DEF_TAG:  r_def_tag   <= i_cfg_data[tmfb_pkg::TagW-1:0];
                tmfb_pkg::CFG_DEF_STMP: r_def_stamp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // scan trackers and pending entry are payload only
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_qstamp <= i_in_data.stamp;
        end
        if (r_state == S_SCAN && w_live) begin
            if (r_idx == '0 || w_head.stamp < r_old.stamp) begin
                r_old <= w_head;
            end
            if (r_idx == '0 || w_d < r_best_d) begin
                r_best_d     <= w_d;
                r_best_stamp <= w_head.stamp;
            end
        end
        if (r_state == S_EMIT && w_step && w_rm) begin
            r_pend <= w_head;
        end
        if (r_state == S_IDLE && w_in_xfer) begin
            r_res <= '{(r_held_v ? r_held_tag : r_def_tag), r_def_stamp,
                       tmfb_pkg::ST_DEFAULT, 1'b1};
        end else if (r_state == S_DECIDE) begin
            r_res <= '{r_old.tag, r_old.stamp, tmfb_pkg::ST_GROWN, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_ws       <= '0;
            r_cap      <= CW'(CAP0);
            r_idx      <= '0;
            r_rm       <= '0;
            r_below    <= '0;
            r_held_tag <= '0;
            r_held_v   <= 1'b0;
            r_pend_v   <= 1'b0;
            r_res_v    <= 1'b0;
        end else begin
            if (r_res_v && w_out_free) begin
                r_res_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_idx    <= '0;
                    r_rm     <= '0;
                    r_below  <= '0;
                    r_pend_v <= 1'b0;
                    if (w_in_xfer) begin
                        if (i_in_data.mode == tmfb_pkg::MODE_PUT) begin
                            if (w_slot == r_count) begin
                                r_count <= r_count + CW'(1);
                            end
                            r_ws <= (w_ws_inc >= r_cap) ? '0 : w_ws_inc;
                        end else if (r_count == '0) begin
                            r_res_v <= 1'b1;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + CW'(1);
                    if (w_last_step) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_idx <= '0;
                    if (r_old.stamp > r_qstamp) begin
                        r_cap   <= (w_cap2 > (CW+1)'(DEPTH)) ? CW'(DEPTH) : w_cap2[CW-1:0];
                        r_res_v <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_step) begin
                        r_idx <= r_idx + CW'(1);
                        if (w_rm) begin
                            r_pend_v <= 1'b1;
                            r_rm     <= r_rm + CW'(1);
                            if (r_idx < r_ws) begin
                                r_below <= r_below + CW'(1);
                            end
                        end
                        if (w_last_step) begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (w_out_free) begin
                        r_held_tag <= r_pend.tag;
                        r_held_v   <= 1'b1;
                        r_ws       <= r_ws - r_below;
                        r_state    <= S_COMPACT;
                    end
                end
                S_COMPACT: begin
                    r_rm    <= r_rm - CW'(1);
                    r_count <= r_count - CW'(1);
                    if (r_rm == CW'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_ws_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ws < r_cap)
        else $error("write slot not below capacity");

    a_pend_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_rm != '0) || r_state == S_FLUSH |-> r_pend_v)
        else $error("removed entries without a pending transfer");

    a_compact_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COMPACT |-> r_rm != '0 && r_count != '0)
        else $error("compaction with nothing to remove");
`endif

endmodule
